/* sv/lsp_pkg.sv */
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared constants, types and lookup functions of the led strip pattern
// generator.
// ----------------------------------------------------------------------------
package lsp_pkg;

  localparam int PIXELS_DEF  = 10;
  localparam int PIX_W       = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_UP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHASE_COLOR  = 2'd2;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  localparam logic [7:0]  MODE_RESET  = 8'h03;
  localparam logic [23:0] CHASE_RESET = 24'hff00ff;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_BLACK = 2'd0;
  localparam kind_t KIND_TABLE = 2'd1;
  localparam kind_t KIND_CHASE = 2'd2;
  localparam kind_t KIND_WAVE  = 2'd3;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  en;
    logic [15:0] offset;
  } frame_t;

  localparam int FRAME_W = $bits(frame_t);

  function automatic logic [23:0] table_color(input logic [2:0] idx);
    logic [23:0] c;
    case (idx)
      3'd0:    c = 24'hff0000;
      3'd1:    c = 24'h00ff00;
      3'd2:    c = 24'h0000ff;
      3'd3:    c = 24'h7f7f7f;
      3'd4:    c = 24'h00ffff;
      3'd5:    c = 24'hff00ff;
      3'd6:    c = 24'hffff00;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

  // triangular level, black on the last phase
  function automatic logic [7:0] wave_level(input logic [3:0] ph);
    logic [7:0] l;
    case (ph)
      4'd0, 4'd14: l = 8'h01;
      4'd1, 4'd13: l = 8'h03;
      4'd2, 4'd12: l = 8'h07;
      4'd3, 4'd11: l = 8'h0f;
      4'd4, 4'd10: l = 8'h1f;
      4'd5, 4'd9:  l = 8'h3f;
      4'd6, 4'd8:  l = 8'h7f;
      4'd7:        l = 8'hff;
      default:     l = 8'h00;
    endcase
    return l;
  endfunction

  // channel enables as {blue, green, red}
  function automatic logic [2:0] wave_enables(input logic [2:0] sel);
    logic [2:0] e;
    case (sel)
      3'd0:    e = 3'b001;
      3'd1:    e = 3'b010;
      3'd2:    e = 3'b100;
      3'd3:    e = 3'b110;
      3'd4:    e = 3'b101;
      3'd5:    e = 3'b011;
      default: e = 3'b111;
    endcase
    return e;
  endfunction

endpackage

/* sv/lsp_fifo.sv */
// ----------------------------------------------------------------------------
// lsp_fifo
// Short first-in first-out queue of frame descriptors between front and back.
// ----------------------------------------------------------------------------
module lsp_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_FULL);
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/lsp_front.sv */
// ----------------------------------------------------------------------------
// lsp_front
// Configuration registers, phase offset and item classification; queues one
// descriptor per frame that produces pixels.
// ----------------------------------------------------------------------------
module lsp_front import lsp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [15:0]          in_offset_value,
  input  logic                 q_full,
  output logic                 q_push,
  output frame_t               q_data,
  output logic [23:0]          chase_color
);

  logic [7:0]  mode_r, mode_nxt;
  logic        step_up_r, step_up_nxt;
  logic [23:0] chase_color_r, chase_color_nxt;
  logic [15:0] offset_r, offset_nxt;
  logic [15:0] offset_step;
  logic        accept;
  logic        known;
  kind_t       kind;

  assign cfg_ready   = 1'b1;
  assign in_stall    = q_full;
  assign accept      = in_valid && !q_full;
  assign chase_color = chase_color_r;
  assign offset_step = step_up_r ? offset_r + 16'd1 : offset_r - 16'd1;

  always_comb begin
    known = 1'b1;
    kind  = KIND_BLACK;
    case (mode_r) inside
      8'h00:          kind = KIND_BLACK;
      8'h01:          kind = KIND_TABLE;
      8'h03:          kind = KIND_CHASE;
      [8'h10:8'h16]:  kind = KIND_WAVE;
      default:        known = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt        = mode_r;
    step_up_nxt     = step_up_r;
    chase_color_nxt = chase_color_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_PATTERN_MODE: mode_nxt        = cfg_data[7:0];
        REG_STEP_UP:      step_up_nxt     = cfg_data[0];
        REG_CHASE_COLOR:  chase_color_nxt = cfg_data;
        default:          ;
      endcase
    end
  end

  always_comb begin
    offset_nxt = offset_r;
    q_push     = 1'b0;
    if (accept) begin
      if (in_operation == OP_LOAD) begin
        offset_nxt = in_offset_value;
      end else begin
        offset_nxt = offset_step;
        q_push     = known;
      end
    end
  end

  assign q_data.kind   = kind;
  assign q_data.en     = wave_enables(mode_r[2:0]);
  assign q_data.offset = offset_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_RESET;
      step_up_r     <= 1'b0;
      chase_color_r <= CHASE_RESET;
      offset_r      <= '0;
    end else begin
      mode_r        <= mode_nxt;
      step_up_r     <= step_up_nxt;
      chase_color_r <= chase_color_nxt;
      offset_r      <= offset_nxt;
    end
  end

endmodule

/* sv/lsp_back.sv */
// ----------------------------------------------------------------------------
// lsp_back
// Pixel engine: for each queued frame, walks the strip one pixel per cycle
// while the output is not stalled; holds the result in an output register.
// ----------------------------------------------------------------------------
module lsp_back import lsp_pkg::*; #(
  parameter int PIXELS = PIXELS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  frame_t           q_data,
  output logic             q_pop,
  input  logic [23:0]      chase_color,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] out_pixel_index,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic             out_last_pixel
);

  localparam logic [PIX_W-1:0] LAST = PIX_W'(PIXELS - 1);

  logic             busy_r, busy_nxt;
  frame_t           frame_r;
  logic [PIX_W-1:0] pix_r, pix_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] idx_r;
  logic [23:0]      rgb_r, rgb;
  logic             last_r;
  logic             is_last, out_free, emit;

  assign is_last  = (pix_r == LAST);
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = busy_r && out_free;
  assign q_pop    = q_valid && (!busy_r || (out_free && is_last));

  always_comb begin
    logic [5:0] ph6;
    logic [4:0] ph5;
    logic [2:0] sh;
    logic [7:0] lvl;
    ph6 = pix_r + frame_r.offset[5:0];
    ph5 = {pix_r[2:0], 2'b00} + frame_r.offset[4:0];
    sh  = (ph5 >= 5'd6) ? 3'(ph5 - 5'd6) : 3'(5'd6 - ph5);
    lvl = wave_level(ph6[3:0]);
    rgb = '0;
    case (frame_r.kind)
      KIND_TABLE: rgb = table_color(ph6[2:0]);
      KIND_CHASE: begin
        if (ph5 <= 5'd12) begin
          rgb = {chase_color[23:16] >> sh, chase_color[15:8] >> sh,
                 chase_color[7:0] >> sh};
        end
      end
      KIND_WAVE: begin
        rgb = {frame_r.en[0] ? lvl : 8'h00, frame_r.en[1] ? lvl : 8'h00,
               frame_r.en[2] ? lvl : 8'h00};
      end
      default: rgb = '0;
    endcase
  end

  always_comb begin
    pix_nxt       = pix_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    if (emit) begin
      out_valid_nxt = 1'b1;
      pix_nxt       = is_last ? '0 : pix_r + 1'b1;
      if (is_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pix_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pix_r       <= pix_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      frame_r <= q_data;
    end
    if (emit) begin
      idx_r  <= pix_r;
      rgb_r  <= rgb;
      last_r <= is_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = idx_r;
  assign out_red         = rgb_r[23:16];
  assign out_green       = rgb_r[15:8];
  assign out_blue        = rgb_r[7:0];
  assign out_last_pixel  = last_r;

endmodule

/* sv/led_strip_pattern_generator.sv */
// ----------------------------------------------------------------------------
// led_strip_pattern_generator
// Frame generator for an addressable led strip.
// ----------------------------------------------------------------------------
// A load item only sets the phase offset. A frame item steps the offset
// and, for a known pattern mode, produces PIXELS pixel items, one per cycle
// when the output is not stalled; consecutive frames follow with no gap. The
// front end accepts items while the two-entry frame queue has room, so input
// items keep flowing while the pixel engine works on earlier frames.
// Configuration is always ready and should be written only while idle.
module led_strip_pattern_generator import lsp_pkg::*; #(
  parameter int PIXELS = PIXELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [15:0]          in_offset_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     out_pixel_index,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic                 out_last_pixel
);

  logic        q_full, q_push, q_pop, q_valid;
  frame_t      q_wdata, q_rdata;
  logic [23:0] chase_color;

  lsp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_offset_value (in_offset_value),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_wdata),
    .chase_color     (chase_color)
  );

  lsp_fifo #(
    .W     (FRAME_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_rdata)
  );

  lsp_back #(
    .PIXELS (PIXELS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_rdata),
    .q_pop           (q_pop),
    .chase_color     (chase_color),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_index (out_pixel_index),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_last_pixel  (out_last_pixel)
  );

endmodule
